>>> hdl/cfbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame builder package
// Byte positions of a frame, request codes and the CRC-16/KERMIT byte table.
// ----------------------------------------------------------------------------
package cfbc_pkg;

    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 24;
    localparam int LEN_W       = 16;
    localparam int CRC_W       = 16;
    localparam int START_W     = 32;
    localparam int IDX_W       = 4;
    localparam int CRC_ENTRIES = 256;

    localparam logic [CRC_W-1:0] CRC_POLY = 16'h8408;

    localparam logic REQ_HEADER  = 1'b0;
    localparam logic REQ_PAYLOAD = 1'b1;

    // Position of each emitted byte within one item.
    localparam logic [IDX_W-1:0] IDX_START0 = 4'd0;
    localparam logic [IDX_W-1:0] IDX_START1 = 4'd1;
    localparam logic [IDX_W-1:0] IDX_START2 = 4'd2;
    localparam logic [IDX_W-1:0] IDX_START3 = 4'd3;
    localparam logic [IDX_W-1:0] IDX_CMD    = 4'd4;
    localparam logic [IDX_W-1:0] IDX_SUB    = 4'd5;
    localparam logic [IDX_W-1:0] IDX_PARAM  = 4'd6;
    localparam logic [IDX_W-1:0] IDX_ADDR0  = 4'd7;
    localparam logic [IDX_W-1:0] IDX_ADDR1  = 4'd8;
    localparam logic [IDX_W-1:0] IDX_ADDR2  = 4'd9;
    localparam logic [IDX_W-1:0] IDX_LEN_LO = 4'd10;
    // Length high byte for a header, the data byte for a payload word.
    localparam logic [IDX_W-1:0] IDX_SPLIT  = 4'd11;
    localparam logic [IDX_W-1:0] IDX_CRC_LO = 4'd12;
    localparam logic [IDX_W-1:0] IDX_CRC_HI = 4'd13;

    typedef logic [CRC_W-1:0] crc_table_t [CRC_ENTRIES];

    function automatic crc_table_t build_crc_table();
        crc_table_t       tbl;
        logic [CRC_W-1:0] c;
        for (int i = 0; i < CRC_ENTRIES; i++)
        begin
            c = CRC_W'(i);
            for (int k = 0; k < BYTE_W; k++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam crc_table_t CRC_TABLE = build_crc_table();

endpackage

>>> hdl/command_frame_builder_crc16_unit.sv
`timescale 1ns / 1ps
// The first byte of a word reaches the output through the item stage and the output register.
// Throughput: one output byte per cycle while the output register is free. A header word gives
// 12 or 14 bytes, a payload word 1, or 3 when it closes the frame with the CRC; a dropped one none.
// The single item stage emits these bytes one per cycle into the output register when it is free.
// Reset clears the frame state, the CRC, the start word and both valid flags.
// ----------------------------------------------------------------------------
// Command frame builder with CRC-16/KERMIT
// Serializes header and payload words into frame bytes and appends the CRC.
// ----------------------------------------------------------------------------
module command_frame_builder_crc16_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [cfbc_pkg::START_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [cfbc_pkg::BYTE_W-1:0]   cmd_class,
    input  logic [cfbc_pkg::BYTE_W-1:0]   sub_cmd,
    input  logic [cfbc_pkg::BYTE_W-1:0]   param,
    input  logic [cfbc_pkg::ADDR_W-1:0]   target_addr,
    input  logic [cfbc_pkg::LEN_W-1:0]    payload_len,
    input  logic                          has_payload,
    input  logic [cfbc_pkg::BYTE_W-1:0]   payload_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cfbc_pkg::BYTE_W-1:0]   frame_byte,
    output logic                          frame_last
);
    import cfbc_pkg::*;

    logic [START_W-1:0] start_word_reg;

    logic               stage_valid_reg, stage_valid_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               req_type_reg;
    logic [BYTE_W-1:0]  cmd_class_reg;
    logic [BYTE_W-1:0]  sub_cmd_reg;
    logic [BYTE_W-1:0]  param_reg;
    logic [ADDR_W-1:0]  target_addr_reg;
    logic [LEN_W-1:0]   payload_len_reg;
    logic               has_payload_reg;
    logic [BYTE_W-1:0]  payload_byte_reg;

    logic               frame_open_reg, frame_open_next;
    logic [LEN_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [CRC_W-1:0]   running_crc_reg, running_crc_next;

    logic               out_valid_reg;
    logic [BYTE_W-1:0]  frame_byte_reg;
    logic               frame_last_reg;

    logic               is_header;
    logic               drop;
    logic               out_free;
    logic               emit;
    logic               stay_open;
    logic               item_last;
    logic               item_done;
    logic               accept;
    logic [BYTE_W-1:0]  cur_byte;
    logic [CRC_W-1:0]   crc_base;
    logic [CRC_W-1:0]   crc_fold;

    assign is_header = (req_type_reg == REQ_HEADER);
    assign drop      = stage_valid_reg && !is_header && !frame_open_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = stage_valid_reg && !drop && out_free;
    assign stay_open = is_header ? (has_payload_reg && (payload_len_reg != '0))
                                 : (bytes_left_reg != LEN_W'(1));
    assign item_last = ((idx_reg == IDX_SPLIT) && stay_open) || (idx_reg == IDX_CRC_HI);
    assign item_done = drop || (emit && item_last);
    assign in_ready  = !stage_valid_reg || item_done;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        unique case (idx_reg)
            IDX_START0: cur_byte = start_word_reg[7:0];
            IDX_START1: cur_byte = start_word_reg[15:8];
            IDX_START2: cur_byte = start_word_reg[23:16];
            IDX_START3: cur_byte = start_word_reg[31:24];
            IDX_CMD:    cur_byte = cmd_class_reg;
            IDX_SUB:    cur_byte = sub_cmd_reg;
            IDX_PARAM:  cur_byte = param_reg;
            IDX_ADDR0:  cur_byte = target_addr_reg[7:0];
            IDX_ADDR1:  cur_byte = target_addr_reg[15:8];
            IDX_ADDR2:  cur_byte = target_addr_reg[23:16];
            IDX_LEN_LO: cur_byte = payload_len_reg[7:0];
            IDX_SPLIT:  cur_byte = is_header ? payload_len_reg[15:8] : payload_byte_reg;
            IDX_CRC_LO: cur_byte = running_crc_reg[7:0];
            IDX_CRC_HI: cur_byte = running_crc_reg[15:8];
            default:    cur_byte = '0;
        endcase
    end

    // A header starts its frame from a cleared CRC.
    assign crc_base = (is_header && (idx_reg == IDX_START0)) ? '0 : running_crc_reg;
    assign crc_fold = (crc_base >> 8) ^ CRC_TABLE[crc_base[7:0] ^ cur_byte];

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        idx_next         = idx_reg;
        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        running_crc_next = running_crc_reg;

        if (emit)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (idx_reg < IDX_CRC_LO)
            begin
                running_crc_next = crc_fold;
            end
            if (idx_reg == IDX_SPLIT)
            begin
                if (is_header)
                begin
                    frame_open_next = stay_open;
                    bytes_left_next = payload_len_reg;
                end
                else
                begin
                    bytes_left_next = bytes_left_reg - LEN_W'(1);
                end
            end
            if (idx_reg == IDX_CRC_HI)
            begin
                running_crc_next = '0;
                frame_open_next  = 1'b0;
                bytes_left_next  = '0;
            end
        end

        if (item_done)
        begin
            stage_valid_next = 1'b0;
        end
        if (accept)
        begin
            stage_valid_next = 1'b1;
            idx_next         = (req_type == REQ_PAYLOAD) ? IDX_SPLIT : IDX_START0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg  <= '0;
            stage_valid_reg <= 1'b0;
            idx_reg         <= IDX_START0;
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= '0;
            running_crc_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                start_word_reg <= cfg_wr_data;
            end
            stage_valid_reg <= stage_valid_next;
            idx_reg         <= idx_next;
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            running_crc_reg <= running_crc_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg     <= req_type;
            cmd_class_reg    <= cmd_class;
            sub_cmd_reg      <= sub_cmd;
            param_reg        <= param;
            target_addr_reg  <= target_addr;
            payload_len_reg  <= payload_len;
            has_payload_reg  <= has_payload;
            payload_byte_reg <= payload_byte;
        end
        if (emit)
        begin
            frame_byte_reg <= cur_byte;
            frame_last_reg <= (idx_reg == IDX_CRC_HI);
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign frame_last = frame_last_reg;

    // An item in the stage never points past the second CRC byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg |-> (idx_reg <= IDX_CRC_HI))
        else $error("item stage index out of range");

    // An open frame expects at least one more payload byte until its CRC goes out.
    assert property (@(posedge clk) disable iff (!rst_n)
        (frame_open_reg && !(stage_valid_reg && (idx_reg >= IDX_CRC_LO)))
            |-> (bytes_left_reg != '0))
        else $error("open frame with no bytes left");

    // Sending the final CRC byte closes the frame and clears the CRC.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (idx_reg == IDX_CRC_HI)) |=> (!frame_open_reg && (running_crc_reg == '0)))
        else $error("frame not closed after CRC");

endmodule

>>> bench/tb_command_frame_builder_crc16_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the command frame builder with CRC-16/KERMIT
// A short table of directed words, then random frame sequences under three
// idling mixes; each byte is checked against an in-bench predictor or a zero frame.
// ----------------------------------------------------------------------------
module tb_command_frame_builder_crc16_unit;

    import cfbc_pkg::*;

    typedef struct packed {
        logic                req_type;
        logic [BYTE_W-1:0]   cmd_class;
        logic [BYTE_W-1:0]   sub_cmd;
        logic [BYTE_W-1:0]   param;
        logic [ADDR_W-1:0]   target_addr;
        logic [LEN_W-1:0]    payload_len;
        logic                has_payload;
        logic [BYTE_W-1:0]   payload_byte;
    } word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] fbyte;
        logic              last;
    } frame_out_t;

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_ZERO_FRAME} row_exp_t;

    typedef struct packed {
        row_kind_t          kind;
        row_exp_t           exp_kind;
        word_t              word;
        logic [START_W-1:0] cfg_value;
    } dir_row_t;

    localparam word_t NO_WORD     = '0;
    localparam int    ZERO_FRAME_BYTES = 14;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [START_W-1:0] cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               req_type = 1'b0;
    logic [BYTE_W-1:0]  cmd_class = '0;
    logic [BYTE_W-1:0]  sub_cmd = '0;
    logic [BYTE_W-1:0]  param = '0;
    logic [ADDR_W-1:0]  target_addr = '0;
    logic [LEN_W-1:0]   payload_len = '0;
    logic               has_payload = 1'b0;
    logic [BYTE_W-1:0]  payload_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [BYTE_W-1:0]  frame_byte;
    logic               frame_last;

    // Predictor state.
    logic [START_W-1:0] pred_start_word;
    logic               pred_frame_open;
    logic [LEN_W-1:0]   pred_bytes_left;
    logic [CRC_W-1:0]   pred_crc;

    frame_out_t step_bytes[$];
    frame_out_t frame_bytes_due[$];
    frame_out_t got_due;
    dir_row_t   dir_table[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int errors;
    int live_words;
    int dropped_words;
    int bytes_checked;
    int start_settings;
    int phase_base;

    command_frame_builder_crc16_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .cmd_class    (cmd_class),
        .sub_cmd      (sub_cmd),
        .param        (param),
        .target_addr  (target_addr),
        .payload_len  (payload_len),
        .has_payload  (has_payload),
        .payload_byte (payload_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .frame_byte   (frame_byte),
        .frame_last   (frame_last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb_command_frame_builder_crc16_unit: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, actual %h last %b",
                         $time, frame_byte, frame_last);
                errors++;
            end
            else
            begin
                got_due = frame_bytes_due.pop_front();
                bytes_checked++;
                if (frame_byte !== got_due.fbyte)
                begin
                    $display("%0t: frame_byte mismatch: expected %h, actual %h",
                             $time, got_due.fbyte, frame_byte);
                    errors++;
                end
                if (frame_last !== got_due.last)
                begin
                    $display("%0t: frame_last mismatch: expected %b, actual %b",
                             $time, got_due.last, frame_last);
                    errors++;
                end
            end
        end
    end

    function automatic logic [CRC_W-1:0] kermit_next(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        end
        return c;
    endfunction

    function automatic void emit_byte(input logic [BYTE_W-1:0] b, input logic last,
                                      input logic fold);
        step_bytes.push_back('{fbyte: b, last: last});
        if (fold)
        begin
            pred_crc = kermit_next(pred_crc, b);
        end
    endfunction

    function automatic void emit_crc();
        emit_byte(pred_crc[7:0], 1'b0, 1'b0);
        emit_byte(pred_crc[15:8], 1'b1, 1'b0);
        pred_crc = '0;
    endfunction

    // Works out the bytes that one accepted word produces and updates the state.
    function automatic void frame_bytes_for_word(input word_t w);
        logic [BYTE_W-1:0] hdr [12];
        step_bytes.delete();
        if (w.req_type == REQ_HEADER)
        begin
            pred_crc        = '0;
            pred_frame_open = 1'b0;
            pred_bytes_left = '0;
            for (int i = 0; i < 4; i++)
            begin
                hdr[i] = pred_start_word[8*i +: 8];
            end
            hdr[4]  = w.cmd_class;
            hdr[5]  = w.sub_cmd;
            hdr[6]  = w.param;
            hdr[7]  = w.target_addr[7:0];
            hdr[8]  = w.target_addr[15:8];
            hdr[9]  = w.target_addr[23:16];
            hdr[10] = w.payload_len[7:0];
            hdr[11] = w.payload_len[15:8];
            for (int i = 0; i < 12; i++)
            begin
                emit_byte(hdr[i], 1'b0, 1'b1);
            end
            if (w.has_payload && w.payload_len != 0)
            begin
                pred_frame_open = 1'b1;
                pred_bytes_left = w.payload_len;
            end
            else
            begin
                emit_crc();
            end
        end
        else if (pred_frame_open)
        begin
            emit_byte(w.payload_byte, 1'b0, 1'b1);
            pred_bytes_left = pred_bytes_left - 1'b1;
            if (pred_bytes_left == 0)
            begin
                emit_crc();
                pred_frame_open = 1'b0;
            end
        end
    endfunction

    function automatic word_t hdr_w(input logic [7:0] cmd, input logic [7:0] sub,
                                    input logic [7:0] prm, input logic [23:0] addr,
                                    input logic [15:0] len, input logic has);
        word_t w;
        w              = '0;
        w.req_type     = REQ_HEADER;
        w.cmd_class    = cmd;
        w.sub_cmd      = sub;
        w.param        = prm;
        w.target_addr  = addr;
        w.payload_len  = len;
        w.has_payload  = has;
        return w;
    endfunction

    function automatic word_t pl_w(input logic [7:0] b, input logic fill);
        word_t w;
        w              = '0;
        w.req_type     = REQ_PAYLOAD;
        w.cmd_class    = {8{fill}};
        w.sub_cmd      = {8{fill}};
        w.param        = {8{fill}};
        w.target_addr  = {24{fill}};
        w.payload_len  = {16{fill}};
        w.has_payload  = fill;
        w.payload_byte = b;
        return w;
    endfunction

    function automatic word_t random_header(input logic has, input logic [15:0] len);
        word_t w;
        w = hdr_w(8'($urandom), 8'($urandom), 8'($urandom), 24'($urandom), len, has);
        w.payload_byte = 8'($urandom);
        return w;
    endfunction

    function automatic word_t random_payload();
        word_t w;
        w = pl_w(8'($urandom), 1'b0);
        w.cmd_class   = 8'($urandom);
        w.sub_cmd     = 8'($urandom);
        w.param       = 8'($urandom);
        w.target_addr = 24'($urandom);
        w.payload_len = 16'($urandom);
        w.has_payload = 1'($urandom);
        return w;
    endfunction

    task automatic send_word(input word_t w, input row_exp_t exp_kind);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= w.req_type;
        cmd_class    <= w.cmd_class;
        sub_cmd      <= w.sub_cmd;
        param        <= w.param;
        target_addr  <= w.target_addr;
        payload_len  <= w.payload_len;
        has_payload  <= w.has_payload;
        payload_byte <= w.payload_byte;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        frame_bytes_for_word(w);
        if (step_bytes.size() == 0)
        begin
            dropped_words++;
        end
        else
        begin
            live_words++;
        end
        case (exp_kind)
            EXP_PREDICT:
            begin
                foreach (step_bytes[i])
                begin
                    frame_bytes_due.push_back(step_bytes[i]);
                end
            end
            EXP_ZERO_FRAME:
            begin
                for (int i = 0; i < ZERO_FRAME_BYTES; i++)
                begin
                    frame_bytes_due.push_back('{fbyte: 8'h00,
                                                last: (i == ZERO_FRAME_BYTES - 1)});
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (frame_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic program_start_word(input logic [START_W-1:0] value);
        drain_outputs();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en       <= 1'b0;
        pred_start_word = value;
        start_settings++;
    endtask

    task automatic random_sequence();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            send_word(random_header(1'b1, 16'(len)), EXP_PREDICT);
            repeat (len) send_word(random_payload(), EXP_PREDICT);
        end
        else if (pick < 75)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                send_word(random_header(1'b1, 16'h0000), EXP_PREDICT);
            end
            else
            begin
                send_word(random_header(1'b0, 16'($urandom)), EXP_PREDICT);
            end
        end
        else if (pick < 90)
        begin
            len = $urandom_range(4, 65535);
            send_word(random_header(1'b1, 16'(len)), EXP_PREDICT);
            repeat ($urandom_range(0, 3)) send_word(random_payload(), EXP_PREDICT);
        end
        else
        begin
            repeat ($urandom_range(1, 3)) send_word(random_payload(), EXP_PREDICT);
        end
    endtask

    initial
    begin
        errors          = 0;
        live_words      = 0;
        dropped_words   = 0;
        bytes_checked   = 0;
        start_settings  = 0;
        tx_idle_pct     = 8;
        rx_idle_pct     = 87;
        pred_start_word = '0;
        pred_frame_open = 1'b0;
        pred_bytes_left = '0;
        pred_crc        = '0;

        dir_table.push_back('{ROW_WORD, EXP_NONE, pl_w(8'h3c, 1'b0), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_ZERO_FRAME, hdr_w(0, 0, 0, 0, 0, 1'b0), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_ZERO_FRAME, hdr_w(0, 0, 0, 0, 0, 1'b1), 32'h0});
        dir_table.push_back('{ROW_CFG, EXP_PREDICT, NO_WORD, 32'hffff_ffff});
        dir_table.push_back('{ROW_WORD, EXP_PREDICT,
                              hdr_w(8'hff, 8'hff, 8'hff, 24'hffffff, 16'hffff, 1'b0), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_PREDICT,
                              hdr_w(8'h01, 8'h80, 8'h7f, 24'h800001, 16'd2, 1'b1), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_PREDICT, pl_w(8'h00, 1'b0), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_PREDICT, pl_w(8'hff, 1'b1), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_NONE, pl_w(8'h42, 1'b1), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_PREDICT,
                              hdr_w(8'h10, 8'h20, 8'h30, 24'h123456, 16'hffff, 1'b1), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_PREDICT, pl_w(8'ha5, 1'b0), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_PREDICT,
                              hdr_w(8'h55, 8'haa, 8'h00, 24'h00ff00, 16'd1, 1'b1), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_PREDICT, pl_w(8'h5a, 1'b1), 32'h0});
        dir_table.push_back('{ROW_CFG, EXP_PREDICT, NO_WORD, 32'h0000_0000});
        dir_table.push_back('{ROW_WORD, EXP_ZERO_FRAME, hdr_w(0, 0, 0, 0, 0, 1'b1), 32'h0});
        dir_table.push_back('{ROW_CFG, EXP_PREDICT, NO_WORD, 32'h8000_0001});
        dir_table.push_back('{ROW_WORD, EXP_PREDICT,
                              hdr_w(8'hc3, 8'h3c, 8'h81, 24'hfedcba, 16'h0100, 1'b0), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_PREDICT,
                              hdr_w(8'h02, 8'h04, 8'h08, 24'h000001, 16'h0001, 1'b1), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_PREDICT, pl_w(8'h80, 1'b0), 32'h0});
        dir_table.push_back('{ROW_WORD, EXP_NONE, pl_w(8'h01, 1'b0), 32'h0});

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_CFG)
            begin
                program_start_word(dir_table[i].cfg_value);
            end
            else
            begin
                send_word(dir_table[i].word, dir_table[i].exp_kind);
            end
        end

        program_start_word($urandom);
        phase_base = live_words;
        while (live_words - phase_base < 142)
        begin
            random_sequence();
        end

        program_start_word($urandom);
        tx_idle_pct = 87;
        rx_idle_pct = 8;
        phase_base  = live_words;
        while (live_words - phase_base < 142)
        begin
            random_sequence();
        end

        program_start_word(32'hffff_ffff);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        phase_base  = live_words;
        while (live_words - phase_base < 142)
        begin
            random_sequence();
        end

        drain_outputs();
        repeat (8) @(posedge clk);

        $display("Sent %0d frame words and %0d dropped payload words under %0d start words.",
                 live_words, dropped_words, start_settings);
        $display("Checked %0d frame bytes across three idling mixes.", bytes_checked);
        if (errors == 0)
        begin
            $display("tb_command_frame_builder_crc16_unit: done, clean");
        end
        else
        begin
            $display("tb_command_frame_builder_crc16_unit: done, errors");
        end
        $finish;
    end

endmodule
